// ----- sv/pfa_pkg.sv -----
// Package for the partition fit allocator.
// Holds field widths, operation and status codes, fit modes and the controller state type.
// No dependencies.
package pfa_pkg;

    // Default sizing of the partition table
    localparam int NUM_BLOCKS_DEF = 32;
    localparam int SIZE_BITS_DEF  = 16;

    // Fixed field widths of the stream items
    localparam int IDX_FIELD_W  = 5;
    localparam int SIZE_FIELD_W = 16;
    localparam int DATA_W       = 24;
    localparam int MODE_W       = 2;
    localparam int COUNT_W      = 6;
    localparam int CFG_DATA_W   = 6;
    localparam int CFG_INDEX_W  = 1;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_FIT_MODE    = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_COUNT = 1'b1;

    // Reset value of the partition count register
    localparam logic [COUNT_W-1:0] BLOCK_COUNT_RST = 6'd32;

    typedef enum logic {
        OP_LOAD     = 1'b0,
        OP_ALLOCATE = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        ST_LOADED  = 2'd0,
        ST_GRANTED = 2'd1,
        ST_WAIT    = 2'd2
    } t_status;

    // Mode code 3 is unused and behaves as first fit
    localparam logic [MODE_W-1:0] FIT_FIRST = 2'd0;
    localparam logic [MODE_W-1:0] FIT_BEST  = 2'd1;
    localparam logic [MODE_W-1:0] FIT_WORST = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0]  fit_mode;
        logic [COUNT_W-1:0] block_count;
    } t_cfg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

endpackage

// ----- sv/pfa_mem.sv -----
// Free size table of the partition fit allocator.
// Simple dual-port memory: one write port, one read port with registered data.
// No dependencies.
module pfa_mem #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered data
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/pfa_ctrl.sv -----
// Controller of the partition fit allocator: item intake, table scan, write-back, result register.
// Depends on pfa_pkg; drives the ports of pfa_mem.
module pfa_ctrl
    import pfa_pkg::*;
#(
    parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
    parameter int SIZE_BITS  = SIZE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cfg                          i_cfg,
    // Input item
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_opcode,
    input  logic [IDX_FIELD_W-1:0]        i_block_index,
    input  logic [SIZE_FIELD_W-1:0]       i_size_value,
    // Result item
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [1:0]                    o_status,
    output logic [IDX_FIELD_W-1:0]        o_chosen_block,
    output logic [SIZE_FIELD_W-1:0]       o_left_over,
    // Table memory
    output logic                          o_mem_we,
    output logic [$clog2(NUM_BLOCKS)-1:0] o_mem_waddr,
    output logic [SIZE_BITS-1:0]          o_mem_wdata,
    output logic [$clog2(NUM_BLOCKS)-1:0] o_mem_raddr,
    input  logic [SIZE_BITS-1:0]          i_mem_rdata
);

    localparam int IDX_W = $clog2(NUM_BLOCKS);
    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
    localparam int LW    = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam logic [LW-1:0] NB_L = LW'(NUM_BLOCKS);

    t_state r_state, n_state;

    // Latched item
    logic                   r_op;
    logic [IDX_FIELD_W-1:0] r_idx;
    logic [SIZE_BITS-1:0]   r_sz;
    logic [LW-1:0]          r_limit;

    // Scan state
    logic [LW-1:0]          r_addr;
    logic                   r_chk_valid;
    logic [IDX_W-1:0]       r_chk_idx;
    logic                   r_found;
    logic [IDX_W-1:0]       r_best_idx;
    logic [SIZE_BITS-1:0]   r_best_val;

    // Result register
    logic                    r_out_valid;
    t_status                 r_status;
    logic [IDX_FIELD_W-1:0]  r_chosen;
    logic [SIZE_FIELD_W-1:0] r_left;

    logic             accept;
    logic             out_free;
    logic             issue;
    logic             scan_end;
    logic             take;
    logic             in_range;
    logic             done_fire;
    logic [LW-1:0]    count_ext;
    logic [SIZE_BITS-1:0] alloc_left;

    assign accept    = i_in_valid && o_in_ready;
    assign out_free  = !r_out_valid || i_out_ready;
    assign issue     = (r_addr < r_limit);
    assign scan_end  = !issue && !r_chk_valid;
    assign in_range  = (32'(r_idx) < 32'(NUM_BLOCKS));
    assign count_ext = LW'(i_cfg.block_count);
    assign alloc_left = r_best_val - r_sz;
    assign done_fire = (r_state == S_DONE) && out_free;

    // A read entry wins if it fits and beats the current pick under the mode
    always_comb begin
        take = 1'b0;
        if (r_chk_valid && (i_mem_rdata >= r_sz)) begin
            if (!r_found) begin
                take = 1'b1;
            end else if (i_cfg.fit_mode == FIT_BEST) begin
                take = (i_mem_rdata < r_best_val);
            end else if (i_cfg.fit_mode == FIT_WORST) begin
                take = (i_mem_rdata > r_best_val);
            end
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (t_opcode'(i_opcode) == OP_ALLOCATE) ? S_SCAN : S_DONE;
                end
            end
            S_SCAN: begin
                if (scan_end) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs of the state machine: intake and memory access
    always_comb begin
        o_in_ready  = (r_state == S_IDLE);
        o_mem_raddr = r_addr[IDX_W-1:0];
        o_mem_we    = 1'b0;
        o_mem_waddr = r_best_idx;
        o_mem_wdata = alloc_left;
        if (done_fire) begin
            if (t_opcode'(r_op) == OP_LOAD) begin
                o_mem_we    = in_range;
                o_mem_waddr = IDX_W'(r_idx);
                o_mem_wdata = r_sz;
            end else begin
                o_mem_we = r_found;
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_chk_valid <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
            r_addr      <= '0;
            r_limit     <= '0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_addr      <= '0;
                r_chk_valid <= 1'b0;
                r_found     <= 1'b0;
                r_limit     <= (count_ext > NB_L) ? NB_L : count_ext;
            end else if (r_state == S_SCAN) begin
                r_chk_valid <= issue;
                if (issue) begin
                    r_addr <= r_addr + 1'b1;
                end
                if (take) begin
                    r_found <= 1'b1;
                end
            end
            if (done_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= i_opcode;
            r_idx <= i_block_index;
            r_sz  <= SIZE_BITS'(i_size_value);
        end
        if (r_state == S_SCAN) begin
            r_chk_idx <= r_addr[IDX_W-1:0];
            if (take) begin
                r_best_idx <= r_chk_idx;
                r_best_val <= i_mem_rdata;
            end
        end
        // Build the result as the item retires
        if (done_fire) begin
            if (t_opcode'(r_op) == OP_LOAD) begin
                r_status <= ST_LOADED;
                r_chosen <= r_idx;
                r_left   <= in_range ? SIZE_FIELD_W'(r_sz) : '0;
            end else if (r_found) begin
                r_status <= ST_GRANTED;
                r_chosen <= IDX_FIELD_W'(r_best_idx);
                r_left   <= SIZE_FIELD_W'(alloc_left);
            end else begin
                r_status <= ST_WAIT;
                r_chosen <= '0;
                r_left   <= '0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_chosen_block = r_chosen;
    assign o_left_over    = r_left;

endmodule

// ----- sv/partition_fit_allocator.sv -----
// Partition fit allocator: first, best or worst fit over a table of free partition sizes.
// A load result is registered from the done state; an allocate result follows a scan of min(block_count,
// NUM_BLOCKS) partitions (none with a zero count), one table read per partition scanned.
// One item is in work at a time: a new item enters only after the last has left the done state,
// and a stalled result holds the next item's write-back, not its entry.
// Synchronous active-low reset clears control and configuration; the table is not cleared.
module partition_fit_allocator
    import pfa_pkg::*;
#(
    parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
    parameter int SIZE_BITS  = SIZE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Configuration write port
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    // Input items
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [DATA_W-1:0]      s_axis_tdata,   // block_index[4:0], size_value[20:5], zero pad
    input  logic                   s_axis_tuser,   // opcode
    // Result items
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [DATA_W-1:0]      m_axis_tdata,   // chosen_block[4:0], left_over[20:5], zero pad
    output logic [1:0]             m_axis_tuser    // status
);

    localparam int IDX_W = $clog2(NUM_BLOCKS);

    t_cfg r_cfg;

    logic                    mem_we;
    logic [IDX_W-1:0]        mem_waddr;
    logic [SIZE_BITS-1:0]    mem_wdata;
    logic [IDX_W-1:0]        mem_raddr;
    logic [SIZE_BITS-1:0]    mem_rdata;
    logic [IDX_FIELD_W-1:0]  chosen_block;
    logic [SIZE_FIELD_W-1:0] left_over;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fit_mode    <= FIT_FIRST;
            r_cfg.block_count <= BLOCK_COUNT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_FIT_MODE:    r_cfg.fit_mode    <= i_cfg_data[MODE_W-1:0];
                REG_BLOCK_COUNT: r_cfg.block_count <= i_cfg_data[COUNT_W-1:0];
                default:         r_cfg             <= r_cfg;
            endcase
        end
    end

    pfa_ctrl #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .SIZE_BITS  (SIZE_BITS)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_in_valid     (s_axis_tvalid),
        .o_in_ready     (s_axis_tready),
        .i_opcode       (s_axis_tuser),
        .i_block_index  (s_axis_tdata[IDX_FIELD_W-1:0]),
        .i_size_value   (s_axis_tdata[IDX_FIELD_W+SIZE_FIELD_W-1:IDX_FIELD_W]),
        .o_out_valid    (m_axis_tvalid),
        .i_out_ready    (m_axis_tready),
        .o_status       (m_axis_tuser),
        .o_chosen_block (chosen_block),
        .o_left_over    (left_over),
        .o_mem_we       (mem_we),
        .o_mem_waddr    (mem_waddr),
        .o_mem_wdata    (mem_wdata),
        .o_mem_raddr    (mem_raddr),
        .i_mem_rdata    (mem_rdata)
    );

    pfa_mem #(
        .DEPTH (NUM_BLOCKS),
        .WIDTH (SIZE_BITS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Pack the result fields, lowest field first
    assign m_axis_tdata = {{(DATA_W - IDX_FIELD_W - SIZE_FIELD_W){1'b0}}, left_over, chosen_block};

endmodule

// ----- bench/alloc_check.sv -----
// Checker for the partition fit allocator: watches the configuration port and both item streams.
// Keeps its own partition table and fit settings, predicts every result and compares it.
// Depends on pfa_pkg.
`timescale 1ns / 1ps

module alloc_check
    import pfa_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Configuration write port, as seen by the block
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    // Input item stream
    input  logic                   i_in_valid,
    input  logic                   i_in_ready,
    input  logic [DATA_W-1:0]      i_in_data,    // block_index[4:0], size_value[20:5], zero pad
    input  logic                   i_in_user,    // opcode
    // Result item stream
    input  logic                   i_out_valid,
    input  logic                   i_out_ready,
    input  logic [DATA_W-1:0]      i_out_data,   // chosen_block[4:0], left_over[20:5], zero pad
    input  logic [1:0]             i_out_user,   // status
    output int                     o_fail_count,
    output int                     o_outstanding
);

    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        t_status                 status;
        logic [IDX_FIELD_W-1:0]  block;
        logic [SIZE_FIELD_W-1:0] left;
    } t_outcome;

    // Shadow copy of the block's table and settings.
    logic [SIZE_BITS_DEF-1:0] free_size [NUM_BLOCKS_DEF];
    logic [MODE_W-1:0]        fit_mode;
    logic [COUNT_W-1:0]       block_count;
    t_outcome                 owed_outcomes [$];

    // Applies one item to the shadow table and returns the result it must produce.
    function automatic t_outcome fit_outcome(t_opcode op, logic [IDX_FIELD_W-1:0] idx,
                                             logic [SIZE_FIELD_W-1:0] size);
        t_outcome res;
        int       span;
        int       pick;
        res.status = ST_LOADED;
        res.block  = idx;
        res.left   = size;
        if (op == OP_LOAD) begin
            free_size[idx] = size;
            return res;
        end
        // A count above the table size searches the whole table.
        span = (block_count > NUM_BLOCKS_DEF) ? NUM_BLOCKS_DEF : int'(block_count);
        pick = -1;
        for (int j = 0; j < span; j++) begin
            if (free_size[j] >= size) begin
                if (pick < 0) begin
                    pick = j;
                end else if (fit_mode == FIT_BEST && free_size[j] < free_size[pick]) begin
                    pick = j;
                end else if (fit_mode == FIT_WORST && free_size[j] > free_size[pick]) begin
                    pick = j;
                end
            end
        end
        if (pick < 0) begin
            res.status = ST_WAIT;
            res.block  = '0;
            res.left   = '0;
        end else begin
            free_size[pick] = free_size[pick] - size;
            res.status = ST_GRANTED;
            res.block  = IDX_FIELD_W'(pick);
            res.left   = free_size[pick];
        end
        return res;
    endfunction

    task automatic flag_mismatch(string what, int got, int want);
        if (o_fail_count < MAX_REPORTS) begin
            $display("%0t: %s mismatch, got %0d, wanted %0d", $time, what, got, want);
        end
        o_fail_count++;
    endtask

    // Results are checked before new items are predicted, since a result always
    // belongs to an item accepted at an earlier edge.
    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            fit_mode     = FIT_FIRST;
            block_count  = BLOCK_COUNT_RST;
            o_fail_count = 0;
            owed_outcomes.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_FIT_MODE) begin
                    fit_mode = i_cfg_data[MODE_W-1:0];
                end else if (i_cfg_index == REG_BLOCK_COUNT) begin
                    block_count = i_cfg_data[COUNT_W-1:0];
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (owed_outcomes.size() == 0) begin
                    flag_mismatch("unrequested result", int'(i_out_user), -1);
                end else begin
                    want = owed_outcomes.pop_front();
                    if (i_out_user !== want.status) begin
                        flag_mismatch("status", int'(i_out_user), int'(want.status));
                    end
                    if (i_out_data[4:0] !== want.block) begin
                        flag_mismatch("chosen_block", int'(i_out_data[4:0]), int'(want.block));
                    end
                    if (i_out_data[20:5] !== want.left) begin
                        flag_mismatch("left_over", int'(i_out_data[20:5]), int'(want.left));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                owed_outcomes.push_back(fit_outcome(t_opcode'(i_in_user), i_in_data[4:0],
                                                    i_in_data[20:5]));
            end
        end
        o_outstanding = owed_outcomes.size();
    end

endmodule

// ----- bench/tb_top.sv -----
// Top of the partition fit allocator testbench: clock, reset, stimulus and verdict.
// Depends on pfa_pkg, partition_fit_allocator and the alloc_check module.
`timescale 1ns / 1ps

module tb_top;
    import pfa_pkg::*;

    localparam int                CYCLE_LIMIT = 1000000;
    localparam int                PHASES      = 10;
    localparam int                PHASE_ITEMS = 125;
    localparam logic [MODE_W-1:0] FIT_SPARE   = 2'd3;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [DATA_W-1:0]      s_axis_tdata;
    logic                   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [DATA_W-1:0]      m_axis_tdata;
    logic [1:0]             m_axis_tuser;

    int                      fail_count;
    int                      outstanding;
    int                      cycle_count;
    int                      burst_left;
    int                      cur_span;
    bit                      steady_sender;
    logic [NUM_BLOCKS_DEF-1:0] loaded_mask;

    partition_fit_allocator DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    alloc_check u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (s_axis_tvalid),
        .i_in_ready    (s_axis_tready),
        .i_in_data     (s_axis_tdata),
        .i_in_user     (s_axis_tuser),
        .i_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .i_out_data    (m_axis_tdata),
        .i_out_user    (m_axis_tuser),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("partition_fit_allocator verification failed");
            $finish;
        end
    end

    // Result side: the stall style is redrawn whenever its random hold runs out.
    initial begin
        int style;
        int hold;
        int run;
        m_axis_tready = 1'b0;
        hold = 0;
        run  = 0;
        forever begin
            @(negedge i_clk);
            if (hold == 0) begin
                style = $urandom_range(0, 3);
                hold  = $urandom_range(50, 300);
            end
            hold--;
            case (style)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= 1'($urandom_range(0, 1));
                2: m_axis_tready <= (hold % 3 == 0);
                default: begin
                    // Long stalls broken by single ready cycles.
                    if (run > 0) begin
                        m_axis_tready <= 1'b0;
                        run--;
                    end else begin
                        m_axis_tready <= 1'b1;
                        run = $urandom_range(4, 24);
                    end
                end
            endcase
        end
    end

    // Sizes lean on the edges, on a small pool that makes ties and exact fits,
    // and on narrow ranges so that requests often fit.
    function automatic logic [SIZE_FIELD_W-1:0] draw_size();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2, 3: return SIZE_FIELD_W'(100 * $urandom_range(1, 4));
            4, 5, 6: return SIZE_FIELD_W'($urandom_range(0, (1 << $urandom_range(1, 12)) - 1));
            default: return SIZE_FIELD_W'($urandom);
        endcase
    endfunction

    // Presents one item and returns at the falling edge after it was taken.
    // Items go out in bursts; valid drops only for a gap between bursts.
    task automatic send_item(t_opcode op, logic [IDX_FIELD_W-1:0] idx,
                             logic [SIZE_FIELD_W-1:0] size);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: gap = 0;
                4, 5, 6, 7: gap = $urandom_range(1, 4);
                8: gap = $urandom_range(5, 20);
                default: gap = $urandom_range(21, 45);
            endcase
            if (steady_sender) begin
                gap = 0;
            end
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        if (op == OP_LOAD) begin
            loaded_mask[idx] = 1'b1;
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {3'b000, size, idx};
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        @(negedge i_clk);
    endtask

    // Stops sending and waits until every result has come back.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        do @(negedge i_clk); while (outstanding != 0);
    endtask

    // Writes both registers on consecutive edges while the block is idle.
    // The spare upper bits of the mode word are random and must be ignored.
    task automatic set_config(logic [MODE_W-1:0] mode, logic [COUNT_W-1:0] count);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_FIT_MODE;
        i_cfg_data  <= {4'($urandom_range(0, 15)), mode};
        @(negedge i_clk);
        i_cfg_index <= REG_BLOCK_COUNT;
        i_cfg_data  <= count;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cur_span = (count > NUM_BLOCKS_DEF) ? NUM_BLOCKS_DEF : int'(count);
    endtask

    // Loads every searched partition not yet written, so no scan reads an unwritten entry.
    task automatic fill_table();
        for (int j = 0; j < cur_span; j++) begin
            if (!loaded_mask[j]) begin
                send_item(OP_LOAD, IDX_FIELD_W'(j), draw_size());
            end
        end
    endtask

    initial begin
        logic [MODE_W-1:0]  mode;
        logic [COUNT_W-1:0] count;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_LOAD;
        cycle_count   = 0;
        burst_left    = 0;
        steady_sender = 1'b0;
        loaded_mask   = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // First fit over four partitions: zero request, full-size exact fit,
        // a request nothing can hold, and a fit that skips emptied partitions.
        set_config(FIT_FIRST, 6'd4);
        send_item(OP_LOAD, 5'd0, 16'hFFFF);
        send_item(OP_LOAD, 5'd1, 16'd0);
        send_item(OP_LOAD, 5'd2, 16'd300);
        send_item(OP_LOAD, 5'd3, 16'd300);
        send_item(OP_ALLOCATE, 5'd31, 16'd0);
        send_item(OP_ALLOCATE, 5'd0, 16'hFFFF);
        send_item(OP_ALLOCATE, 5'd0, 16'd301);
        send_item(OP_ALLOCATE, 5'd0, 16'd300);
        settle();

        // Best fit with two equal smallest candidates.
        set_config(FIT_BEST, 6'd4);
        send_item(OP_LOAD, 5'd0, 16'd500);
        send_item(OP_LOAD, 5'd1, 16'd200);
        send_item(OP_LOAD, 5'd2, 16'd200);
        send_item(OP_ALLOCATE, 5'd0, 16'd150);
        send_item(OP_ALLOCATE, 5'd0, 16'd0);
        settle();

        // Worst fit, then a tie for the largest partition.
        set_config(FIT_WORST, 6'd4);
        send_item(OP_ALLOCATE, 5'd0, 16'd100);
        send_item(OP_LOAD, 5'd3, 16'd400);
        send_item(OP_ALLOCATE, 5'd0, 16'd1);
        settle();

        // The unused mode code behaves as first fit.
        set_config(FIT_SPARE, 6'd4);
        send_item(OP_ALLOCATE, 5'd0, 16'd60);
        settle();

        // With no partition searched every request waits.
        set_config(FIT_FIRST, 6'd0);
        send_item(OP_ALLOCATE, 5'd0, 16'd0);
        settle();

        // An oversized count searches the whole table.
        set_config(FIT_BEST, 6'd63);
        send_item(OP_LOAD, 5'd31, 16'hAAAA);
        send_item(OP_LOAD, 5'd5, 16'h5555);
        fill_table();
        send_item(OP_ALLOCATE, 5'd0, 16'hFFFF);
        send_item(OP_ALLOCATE, 5'd0, 16'h5555);

        // Random phases, each under its own settings.
        for (int phase = 0; phase < PHASES; phase++) begin
            settle();
            mode = MODE_W'($urandom_range(0, 3));
            if (phase == 0) begin
                count = 6'd1;
            end else if (phase == 1) begin
                count = 6'd32;
            end else begin
                case ($urandom_range(0, 7))
                    0: count = 6'd0;
                    1: count = 6'd63;
                    2: count = COUNT_W'($urandom_range(33, 62));
                    3, 4: count = 6'd32;
                    default: count = COUNT_W'($urandom_range(1, 31));
                endcase
            end
            steady_sender = ($urandom_range(0, 3) == 0);
            set_config(mode, count);
            fill_table();
            repeat (PHASE_ITEMS) begin
                if ($urandom_range(0, 9) < 3) begin
                    // Refill, mostly inside the searched range.
                    if (cur_span > 0 && $urandom_range(0, 1) == 1) begin
                        send_item(OP_LOAD, IDX_FIELD_W'($urandom_range(0, cur_span - 1)),
                                  draw_size());
                    end else begin
                        send_item(OP_LOAD, IDX_FIELD_W'($urandom_range(0, 31)), draw_size());
                    end
                end else begin
                    send_item(OP_ALLOCATE, IDX_FIELD_W'($urandom), draw_size());
                end
            end
        end

        settle();
        repeat (40) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("partition_fit_allocator verification clean");
        end else begin
            $display("partition_fit_allocator verification failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/pfa_pkg.sv
sv/pfa_mem.sv
sv/pfa_ctrl.sv
sv/partition_fit_allocator.sv
bench/alloc_check.sv
bench/tb_top.sv
